// ===== hdl/rbe_pkg.sv =====
`default_nettype none
package rbe_pkg;

  // Widths fixed by the item fields
  localparam int COORD_W = 32;
  localparam int EXT_W   = 31;
  localparam int NUM_W   = 34;  // coordinate difference, box corner minus ray origin
  localparam int QUO_W   = 33;  // quotient bits resolved before saturation
  localparam int NUM_EDGES = 4;

  // Edge order and result codes
  localparam logic [1:0] EDGE_LEFT   = 2'd0;
  localparam logic [1:0] EDGE_TOP    = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_BOTTOM = 2'd3;

  localparam logic signed [COORD_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] T_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_center_x;
    logic signed [COORD_W-1:0] box_center_y;
    logic        [EXT_W-1:0]   half_width;
    logic        [EXT_W-1:0]   half_height;
    logic signed [COORD_W-1:0] ray_start_x;
    logic signed [COORD_W-1:0] ray_start_y;
    logic signed [COORD_W-1:0] ray_step_x;
    logic signed [COORD_W-1:0] ray_step_y;
  } in_item_t;

  // One edge handed to a divider: segment test outcome and the t fraction
  typedef struct packed {
    logic                      ok;
    logic signed [NUM_W-1:0]   num;
    logic signed [COORD_W-1:0] den;
  } edge_req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [COORD_W-1:0] t;
  } edge_res_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] ray_param;
    logic        [1:0]         edge_index;
  } res_item_t;

endpackage
`default_nettype wire

// ===== hdl/rbe_in_if.sv =====
`default_nettype none
interface rbe_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      box_center_x;
  logic signed [31:0]      box_center_y;
  logic        [30:0]      half_width;
  logic        [30:0]      half_height;
  logic signed [31:0]      ray_start_x;
  logic signed [31:0]      ray_start_y;
  logic signed [31:0]      ray_step_x;
  logic signed [31:0]      ray_step_y;

  modport source (
    output valid, box_center_x, box_center_y, half_width, half_height,
           ray_start_x, ray_start_y, ray_step_x, ray_step_y,
    input  ready
  );
  modport sink (
    input  valid, box_center_x, box_center_y, half_width, half_height,
           ray_start_x, ray_start_y, ray_step_x, ray_step_y,
    output ready
  );
endinterface
`default_nettype wire

// ===== hdl/rbe_out_if.sv =====
`default_nettype none
interface rbe_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] ray_param;
  logic        [1:0]  edge_index;

  modport source (output valid, hit, ray_param, edge_index, input ready);
  modport sink   (input valid, hit, ray_param, edge_index, output ready);
endinterface
`default_nettype wire

// ===== hdl/rbe_prep.sv =====
`default_nettype none
module rbe_prep (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_i,
  input  wire rbe_pkg::in_item_t    item_i,
  output logic                      vld_o,
  output rbe_pkg::edge_req_t        req_o [rbe_pkg::NUM_EDGES]
);

  localparam int NW = rbe_pkg::NUM_W;
  localparam int CW = rbe_pkg::COORD_W;
  localparam int PW = NW + CW;  // corner difference times direction
  localparam int EW = 2 * CW;   // half extent times direction
  localparam int SW = PW + 2;   // determinant and v numerator

  // Both bounds exact: 0 <= nv/det < 1
  function automatic logic seg_ok(input logic signed [SW-1:0] det,
                                  input logic signed [SW-1:0] nv);
    logic r;
    if (det > 0) begin
      r = (nv >= 0) && (nv < det);
    end else if (det < 0) begin
      r = (nv <= 0) && (nv > det);
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

  // Stage A: corner differences
  logic                 vld_a_r;
  logic signed [NW-1:0] dxl_a_r, dxh_a_r, dyl_a_r, dyh_a_r;
  logic signed [CW-1:0] rx_a_r, ry_a_r, hw_a_r, hh_a_r;

  logic signed [NW-1:0] cx_e, cy_e, hw_e, hh_e, ox_e, oy_e;

  always_comb begin
    cx_e = NW'(item_i.box_center_x);
    cy_e = NW'(item_i.box_center_y);
    ox_e = NW'(item_i.ray_start_x);
    oy_e = NW'(item_i.ray_start_y);
    hw_e = $signed({3'b000, item_i.half_width});
    hh_e = $signed({3'b000, item_i.half_height});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxl_a_r <= cx_e - hw_e - ox_e;
      dxh_a_r <= cx_e + hw_e - ox_e;
      dyl_a_r <= cy_e - hh_e - oy_e;
      dyh_a_r <= cy_e + hh_e - oy_e;
      rx_a_r  <= item_i.ray_step_x;
      ry_a_r  <= item_i.ray_step_y;
      hw_a_r  <= $signed({1'b0, item_i.half_width});
      hh_a_r  <= $signed({1'b0, item_i.half_height});
    end
  end

  // Stage B: the six products
  logic                 vld_b_r;
  logic signed [PW-1:0] pyl_rx_b_r, pyh_rx_b_r, pxl_ry_b_r, pxh_ry_b_r;
  logic signed [EW-1:0] phh_rx_b_r, phw_ry_b_r;
  logic signed [NW-1:0] dxl_b_r, dxh_b_r, dyl_b_r, dyh_b_r;
  logic signed [CW-1:0] rx_b_r, ry_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pyl_rx_b_r <= PW'(dyl_a_r) * PW'(rx_a_r);
      pyh_rx_b_r <= PW'(dyh_a_r) * PW'(rx_a_r);
      pxl_ry_b_r <= PW'(dxl_a_r) * PW'(ry_a_r);
      pxh_ry_b_r <= PW'(dxh_a_r) * PW'(ry_a_r);
      phh_rx_b_r <= EW'(hh_a_r) * EW'(rx_a_r);
      phw_ry_b_r <= EW'(hw_a_r) * EW'(ry_a_r);
      dxl_b_r    <= dxl_a_r;
      dxh_b_r    <= dxh_a_r;
      dyl_b_r    <= dyl_a_r;
      dyh_b_r    <= dyh_a_r;
      rx_b_r     <= rx_a_r;
      ry_b_r     <= ry_a_r;
    end
  end

  // Stage C: determinant and segment parameter per edge
  logic signed [SW-1:0] det_v, det_h, nv_l, nv_t, nv_r, nv_b;

  always_comb begin
    det_v = SW'(phh_rx_b_r) <<< 1;
    det_h = SW'(phw_ry_b_r) <<< 1;
    nv_l  = SW'(pyl_rx_b_r) - SW'(pxl_ry_b_r);
    nv_t  = SW'(pyh_rx_b_r) - SW'(pxl_ry_b_r);
    nv_r  = SW'(pyh_rx_b_r) - SW'(pxh_ry_b_r);
    nv_b  = SW'(pyl_rx_b_r) - SW'(pxh_ry_b_r);
  end

  logic               vld_c_r;
  rbe_pkg::edge_req_t req_c_r [rbe_pkg::NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_c_r[rbe_pkg::EDGE_LEFT]   <= '{ok: seg_ok(-det_v, nv_l), num: dxl_b_r, den: rx_b_r};
      req_c_r[rbe_pkg::EDGE_TOP]    <= '{ok: seg_ok(det_h, nv_t),  num: dyh_b_r, den: ry_b_r};
      req_c_r[rbe_pkg::EDGE_RIGHT]  <= '{ok: seg_ok(det_v, nv_r),  num: dxh_b_r, den: rx_b_r};
      req_c_r[rbe_pkg::EDGE_BOTTOM] <= '{ok: seg_ok(-det_h, nv_b), num: dyl_b_r, den: ry_b_r};
    end
  end

  assign vld_o = vld_c_r;
  assign req_o = req_c_r;

endmodule
`default_nettype wire

// ===== hdl/rbe_div.sv =====
`default_nettype none
module rbe_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               vld_i,
  input  wire rbe_pkg::edge_req_t req_i,
  output logic                    vld_o,
  output rbe_pkg::edge_res_t      res_o
);

  localparam int MW = rbe_pkg::NUM_W;
  localparam int CW = rbe_pkg::COORD_W;
  localparam int QB = rbe_pkg::QUO_W;
  localparam int NW = MW + FRAC_BITS;

  // Setup: magnitudes, early overflow, leading partial remainder
  logic [MW-1:0] num_mag;
  logic [CW-1:0] den_mag;
  logic [NW-1:0] nfull;
  logic [CW-1:0] hi_ext;

  always_comb begin
    num_mag = req_i.num[MW-1] ? MW'(-req_i.num) : MW'(req_i.num);
    den_mag = req_i.den[CW-1] ? CW'(-req_i.den) : CW'(req_i.den);
    nfull   = {num_mag, {FRAC_BITS{1'b0}}};
    hi_ext  = CW'(nfull[NW-1:QB]);
  end

  logic          vld_r [QB+1];
  logic          ok_r  [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];
  logic [CW-1:0] den_r [QB+1];
  logic [CW-1:0] rem_r [QB+1];
  logic [QB-1:0] nlo_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r[0]  <= req_i.ok;
      neg_r[0] <= req_i.num[MW-1] ^ req_i.den[CW-1];
      ovf_r[0] <= hi_ext >= den_mag;
      den_r[0] <= den_mag;
      rem_r[0] <= hi_ext;
      nlo_r[0] <= nfull[QB-1:0];
      quo_r[0] <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [CW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_r[k-1], nlo_r[k-1][QB-k]};
      ge    = trial >= {1'b0, den_r[k-1]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ok_r[k]  <= ok_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        den_r[k] <= den_r[k-1];
        nlo_r[k] <= nlo_r[k-1];
        rem_r[k] <= ge ? CW'(trial - {1'b0, den_r[k-1]}) : trial[CW-1:0];
        quo_r[k] <= {quo_r[k-1][QB-2:0], ge};
      end
    end
  end

  // Sign and saturation
  logic signed [CW-1:0] t_nxt;
  logic [QB-1:0]        q;

  always_comb begin
    q = quo_r[QB];
    if (neg_r[QB]) begin
      if (ovf_r[QB] || (q > QB'({1'b1, {(CW-1){1'b0}}}))) begin
        t_nxt = rbe_pkg::T_MIN;
      end else begin
        t_nxt = $signed(CW'(-q));
      end
    end else begin
      if (ovf_r[QB] || (q > QB'(rbe_pkg::T_MAX))) begin
        t_nxt = rbe_pkg::T_MAX;
      end else begin
        t_nxt = $signed(q[CW-1:0]);
      end
    end
  end

  logic               vld_out_r;
  rbe_pkg::edge_res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= '{ok: ok_r[QB], t: t_nxt};
    end
  end

  assign vld_o = vld_out_r;
  assign res_o = res_r;

endmodule
`default_nettype wire

// ===== hdl/rbe_sel.sv =====
`default_nettype none
module rbe_sel (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               vld_i,
  input  wire rbe_pkg::edge_res_t res_i [rbe_pkg::NUM_EDGES],
  output logic                    vld_o,
  output rbe_pkg::res_item_t      res_o
);

  rbe_pkg::res_item_t res_nxt;

  // Strict compare keeps the earlier edge on a tie
  always_comb begin
    res_nxt = '{hit: 1'b0, ray_param: rbe_pkg::T_MAX, edge_index: rbe_pkg::EDGE_LEFT};
    for (int e = 0; e < rbe_pkg::NUM_EDGES; e++) begin
      if (res_i[e].ok && (!res_nxt.hit || (res_i[e].t < res_nxt.ray_param))) begin
        res_nxt.hit        = 1'b1;
        res_nxt.ray_param  = res_i[e].t;
        res_nxt.edge_index = 2'(e);
      end
    end
  end

  logic               vld_r;
  rbe_pkg::res_item_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

endmodule
`default_nettype wire

// ===== hdl/ray_box_edge_intersect_2d_core.sv =====
// Channel   Direction  Interface   Moves
// in_req    sink       rbe_in_if   one box and one ray per request
// out_res   source     rbe_out_if  hit flag, nearest t, edge index
//
// One request enters per cycle while the output is not stalled; each result passes
// through 3 setup and product stages, 35 divider stages and 1 selection stage. The
// 33-stage restoring divider resolves one quotient bit per stage.
// rst_n is synchronous, active low, and clears the valid bits only.
// A stalled output freezes every stage at once; nothing is dropped or repeated.
`default_nettype none
module ray_box_edge_intersect_2d_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rbe_in_if.sink     in_req,
  rbe_out_if.source  out_res
);

  logic               en;
  logic               prep_vld;
  logic               div_vld;
  logic               out_vld;
  rbe_pkg::in_item_t  item;
  rbe_pkg::edge_req_t edge_req [rbe_pkg::NUM_EDGES];
  rbe_pkg::edge_res_t edge_res [rbe_pkg::NUM_EDGES];
  rbe_pkg::res_item_t res;

  // Advance the whole pipe unless a finished result is held at the output
  assign en           = !out_vld || out_res.ready;
  assign in_req.ready = en;

  always_comb begin
    item.box_center_x = in_req.box_center_x;
    item.box_center_y = in_req.box_center_y;
    item.half_width   = in_req.half_width;
    item.half_height  = in_req.half_height;
    item.ray_start_x  = in_req.ray_start_x;
    item.ray_start_y  = in_req.ray_start_y;
    item.ray_step_x   = in_req.ray_step_x;
    item.ray_step_y   = in_req.ray_step_y;
  end

  // Corner differences, products, segment tests
  rbe_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_req.valid),
    .item_i (item),
    .vld_o  (prep_vld),
    .req_o  (edge_req)
  );

  // One divider per edge; all four run in lockstep, so one valid suffices
  rbe_div #(.FRAC_BITS(FRAC_BITS)) u_div_left (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (prep_vld),
    .req_i (edge_req[rbe_pkg::EDGE_LEFT]), .vld_o (div_vld),
    .res_o (edge_res[rbe_pkg::EDGE_LEFT])
  );

  rbe_div #(.FRAC_BITS(FRAC_BITS)) u_div_top (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (prep_vld),
    .req_i (edge_req[rbe_pkg::EDGE_TOP]), .vld_o (),
    .res_o (edge_res[rbe_pkg::EDGE_TOP])
  );

  rbe_div #(.FRAC_BITS(FRAC_BITS)) u_div_right (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (prep_vld),
    .req_i (edge_req[rbe_pkg::EDGE_RIGHT]), .vld_o (),
    .res_o (edge_res[rbe_pkg::EDGE_RIGHT])
  );

  rbe_div #(.FRAC_BITS(FRAC_BITS)) u_div_bottom (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (prep_vld),
    .req_i (edge_req[rbe_pkg::EDGE_BOTTOM]), .vld_o (),
    .res_o (edge_res[rbe_pkg::EDGE_BOTTOM])
  );

  // Pick the nearest accepted edge and hold it in the output register
  rbe_sel u_sel (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (div_vld),
    .res_i (edge_res),
    .vld_o (out_vld),
    .res_o (res)
  );

  assign out_res.valid      = out_vld;
  assign out_res.hit        = res.hit;
  assign out_res.ray_param  = res.ray_param;
  assign out_res.edge_index = res.edge_index;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;

  localparam int FRAC = 16;
  localparam int ONE = 1 << FRAC;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;

  rbe_in_if  in_if();
  rbe_out_if out_if();

  ray_box_edge_intersect_2d_core #(.FRAC_BITS(FRAC)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_if.sink),
    .out_res (out_if.source)
  );

  rbe_pkg::res_item_t hit_expect_q[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Nearest accepted edge of the box along the ray, exact wide arithmetic.
  function automatic rbe_pkg::res_item_t nearest_edge_hit(rbe_pkg::in_item_t it);
    rbe_pkg::res_item_t r;
    longint cx, cy, hw, hh, ox, oy, rx, ry, dx, dy, num, den, q, best;
    longint sx[4], sy[4], ax[4], ay[4];
    logic signed [127:0] det, nv;
    bit found;
    int e;
    cx = it.box_center_x;
    cy = it.box_center_y;
    hw = it.half_width;
    hh = it.half_height;
    ox = it.ray_start_x;
    oy = it.ray_start_y;
    rx = it.ray_step_x;
    ry = it.ray_step_y;
    sx[0] = cx - hw; sy[0] = cy - hh; ax[0] = 0;       ay[0] = 2 * hh;
    sx[1] = cx - hw; sy[1] = cy + hh; ax[1] = 2 * hw;  ay[1] = 0;
    sx[2] = cx + hw; sy[2] = cy + hh; ax[2] = 0;       ay[2] = -2 * hh;
    sx[3] = cx + hw; sy[3] = cy - hh; ax[3] = -2 * hw; ay[3] = 0;
    best = 64'sh7FFF_FFFF;
    found = 1'b0;
    r.edge_index = rbe_pkg::EDGE_LEFT;
    for (e = 0; e < rbe_pkg::NUM_EDGES; e++) begin
      dx = sx[e] - ox;
      dy = sy[e] - oy;
      det = 128'(ax[e]) * 128'(ry) - 128'(ay[e]) * 128'(rx);
      if (det == 0) continue;
      nv = 128'(dy) * 128'(rx) - 128'(dx) * 128'(ry);
      if (det < 0) begin
        det = -det;
        nv = -nv;
      end
      // v must lie in [0,1): nv in [0, det)
      if (nv < 0 || nv >= det) continue;
      if (ay[e] != 0) begin
        num = dx;
        den = rx;
      end else begin
        num = dy;
        den = ry;
      end
      if (den == 0) continue;
      q = (num * (64'sd1 <<< FRAC)) / den;
      if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
      if (q < -64'sh8000_0000) q = -64'sh8000_0000;
      if (!found || q < best) begin
        found = 1'b1;
        best = q;
        r.edge_index = e[1:0];
      end
    end
    r.hit = found;
    r.ray_param = best[31:0];
    if (!found) r.edge_index = rbe_pkg::EDGE_LEFT;
    return r;
  endfunction

  // Present one request, hold it until accepted, then record its expected result.
  task automatic send_item(rbe_pkg::in_item_t it);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 31) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid        <= 1'b1;
    in_if.box_center_x <= it.box_center_x;
    in_if.box_center_y <= it.box_center_y;
    in_if.half_width   <= it.half_width;
    in_if.half_height  <= it.half_height;
    in_if.ray_start_x  <= it.ray_start_x;
    in_if.ray_start_y  <= it.ray_start_y;
    in_if.ray_step_x   <= it.ray_step_x;
    in_if.ray_step_y   <= it.ray_step_y;
    do @(posedge clk); while (!in_if.ready);
    hit_expect_q.push_back(nearest_edge_hit(it));
  endtask

  function automatic rbe_pkg::in_item_t make_item(int cx, int cy, int hw, int hh,
                                                  int ox, int oy, int rx, int ry);
    rbe_pkg::in_item_t it;
    it.box_center_x = cx;
    it.box_center_y = cy;
    it.half_width   = hw[30:0];
    it.half_height  = hh[30:0];
    it.ray_start_x  = ox;
    it.ray_start_y  = oy;
    it.ray_step_x   = rx;
    it.ray_step_y   = ry;
    return it;
  endfunction

  function automatic int rand_signed(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic test_directed();
    // plain hit on the left edge, t = 3
    send_item(make_item(0, 0, ONE, ONE, -4 * ONE, 0, ONE, 0));
    // hit from each other side
    send_item(make_item(0, 0, ONE, ONE, 0, 4 * ONE, 0, -ONE));
    send_item(make_item(0, 0, ONE, ONE, 4 * ONE, 0, -ONE, 0));
    send_item(make_item(0, 0, ONE, ONE, 0, -4 * ONE, 0, ONE));
    // zero direction, zero extents, parallel ray
    send_item(make_item(0, 0, ONE, ONE, -4 * ONE, 0, 0, 0));
    send_item(make_item(0, 0, 0, 0, -4 * ONE, 0, ONE, 0));
    send_item(make_item(0, 0, 0, ONE, -4 * ONE, 0, ONE, 0));
    send_item(make_item(0, 0, ONE, 0, 0, -4 * ONE, 0, ONE));
    send_item(make_item(0, 0, ONE, ONE, -4 * ONE, ONE, ONE, 0));
    // origin inside: the hit behind counts
    send_item(make_item(0, 0, ONE, ONE, 0, 0, ONE, 0));
    // diagonal through corners: v = 0 taken, v = 1 dropped, ties
    send_item(make_item(0, 0, ONE, ONE, -3 * ONE, -3 * ONE, ONE, ONE));
    send_item(make_item(0, 0, ONE, ONE, -3 * ONE, 3 * ONE, ONE, -ONE));
    send_item(make_item(0, 0, ONE, ONE, -4 * ONE, -ONE, ONE, 0));
    send_item(make_item(0, 0, ONE, ONE, -4 * ONE, ONE - 1, ONE, 0));
    // tiny step saturates t, negative saturation too
    send_item(make_item(0, 0, ONE, ONE, -4 * ONE, 0, 1, 0));
    send_item(make_item(0, 0, ONE, ONE, 4 * ONE, 0, 1, 0));
    // miss
    send_item(make_item(0, 0, ONE, ONE, -4 * ONE, 5 * ONE, ONE, 0));
    // field extremes
    send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_item(make_item(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                        32'h8000_0000, 32'h7FFF_FFFF));
    send_item(make_item(-1, -1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, -1, 1));
  endtask

  // Rays aimed near the box so that most requests hit an edge.
  task automatic test_aimed_rays(int count);
    rbe_pkg::in_item_t it;
    int cx, cy, hw, hh, ox, oy, tx, ty, k;
    repeat (count) begin
      cx = rand_signed(100 * ONE);
      cy = rand_signed(100 * ONE);
      hw = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(0, 20 * ONE));
      hh = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(0, 20 * ONE));
      ox = rand_signed(200 * ONE);
      oy = rand_signed(200 * ONE);
      tx = cx + rand_signed(hw + hw / 2 + 1);
      ty = cy + rand_signed(hh + hh / 2 + 1);
      case ($urandom_range(0, 7))
        0: oy = cy - hh;      // run along the bottom row
        1: ox = cx - hw;      // run along the left column
        2: ty = cy + hh;      // aim at the top row exactly
        default: ;
      endcase
      k = int'($urandom_range(1, 8));
      it = make_item(cx, cy, hw, hh, ox, oy, (tx - ox) / k, (ty - oy) / k);
      if ($urandom_range(0, 9) == 0) it.ray_step_y = 0;
      send_item(it);
    end
  endtask

  // Arbitrary bit patterns for every field.
  task automatic test_random_fields(int count);
    repeat (count) begin
      send_item(make_item($urandom(), $urandom(), $urandom() >> 1, $urandom() >> 1,
                          $urandom(), $urandom(), $urandom(), $urandom()));
    end
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    test_aimed_rays(count);
    no_idle = 1'b0;
  endtask

  // Drive result ready, stalling at random unless in a no-idle stretch.
  always @(posedge clk) begin
    out_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  // Compare each result against the oldest expectation.
  always @(posedge clk) begin
    rbe_pkg::res_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (hit_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0b t=%h edge=%0d",
                                       out_if.hit, out_if.ray_param, out_if.edge_index);
      end else begin
        want = hit_expect_q.pop_front();
        if (out_if.hit !== want.hit || out_if.ray_param !== want.ray_param ||
            out_if.edge_index !== want.edge_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected hit=%0b t=%h edge=%0d, got hit=%0b t=%h edge=%0d",
                     want.hit, want.ray_param, want.edge_index,
                     out_if.hit, out_if.ray_param, out_if.edge_index);
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    no_idle = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    in_if.valid = 1'b0;
    in_if.box_center_x = '0;
    in_if.box_center_y = '0;
    in_if.half_width = '0;
    in_if.half_height = '0;
    in_if.ray_start_x = '0;
    in_if.ray_start_y = '0;
    in_if.ray_step_x = '0;
    in_if.ray_step_y = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_aimed_rays(200);
    test_back_to_back(80);
    test_random_fields(120);
    in_if.valid <= 1'b0;

    wait_cycles = 0;
    while (hit_expect_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && hit_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
